### design/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the stream find-and-replace block
// Holds the item structs, register indexes and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

  // One source byte.
  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              in_final;
  } src_item_t;

  // One result item.
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              run_last;
    logic              string_end;
  } res_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;       // capture the accepted source byte and its final flag
    logic append_in;     // append the accepted byte to the hold buffer
    logic emit_head;     // send the oldest held byte and shift the buffer
    logic append_saved;  // with emit_head: append the captured byte after the shift
    logic clear_cnt;     // drop the whole buffer (pattern consumed)
    logic emit_rep;      // send the next replacement byte
    logic rep_clr;       // restart the replacement index
    logic finish;        // close the run: release the pending result, or an end marker, as last
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rel_need;      // held bytes are no longer a strict prefix of the pattern
    logic cnt_zero;
    logic cnt_one;
    logic plen_zero;
    logic full_match;    // buffer holds the whole pattern
    logic part_match;    // buffer is a strict prefix of the pattern
    logic rlen_zero;
    logic rep_last;      // current replacement byte is the final one
    logic final_seen;    // the captured byte ends the string
    logic pend_valid;    // a result waits in the pending stage
    logic out_free;      // the output register can take a result this cycle
  } dp_status_t;

endpackage

### design/sfr_datapath.sv
// ----------------------------------------------------------------------------
// sfr_datapath: storage and compare logic for find-and-replace
// Holds the configuration registers, the partial-match buffer, the pattern
// comparators, the replacement index, a one-deep pending stage and the
// output register.
// ----------------------------------------------------------------------------
module sfr_datapath
  import sfr_pkg::*;
#(
  parameter int PATTERN_MAX = 8,
  parameter int REPLACE_MAX = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  src_item_t             in_data,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  input  logic                  out_ready,
  output logic                  out_valid,
  output res_item_t             out_data
);

  localparam int CW  = $clog2(PATTERN_MAX + 1);
  localparam int RLW = $clog2(REPLACE_MAX + 1);
  localparam int RIW = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;

  logic [BYTE_W-1:0] pat_r [PATTERN_MAX];
  logic [BYTE_W-1:0] rep_r [REPLACE_MAX];
  logic [LEN_W-1:0]  plen_reg_r;
  logic [LEN_W-1:0]  rlen_reg_r;

  logic [BYTE_W-1:0] hold_r   [PATTERN_MAX];
  logic [BYTE_W-1:0] hold_nxt [PATTERN_MAX];
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     cnt_nxt;
  logic [RIW-1:0]    ridx_r;
  logic [BYTE_W-1:0] byte_r;
  logic              final_r;

  logic              pend_valid_r;
  logic [BYTE_W-1:0] pend_byte_r;
  logic              out_valid_r;
  res_item_t         out_data_r;

  logic [CW-1:0]          plen;
  logic [RLW-1:0]         rlen;
  logic [PATTERN_MAX-1:0] eq;
  logic [PATTERN_MAX-1:0] below_cnt;
  logic [PATTERN_MAX-1:0] below_plen;
  logic                   match_cnt;
  logic                   match_plen;
  logic                   emit;
  logic [BYTE_W-1:0]      emit_byte;

  // Configuration registers; unknown indexes cannot occur with a two-bit index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PATTERN_MAX; i++) pat_r[i] <= '0;
      for (int i = 0; i < REPLACE_MAX; i++) rep_r[i] <= '0;
      plen_reg_r <= '0;
      rlen_reg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_BYTES: begin
          for (int i = 0; i < PATTERN_MAX; i++) pat_r[i] <= cfg_data[BYTE_W*i +: BYTE_W];
        end
        REG_PATTERN_LENGTH:     plen_reg_r <= cfg_data[LEN_W-1:0];
        REG_REPLACEMENT_BYTES: begin
          for (int i = 0; i < REPLACE_MAX; i++) rep_r[i] <= cfg_data[BYTE_W*i +: BYTE_W];
        end
        REG_REPLACEMENT_LENGTH: rlen_reg_r <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Lengths above the build limits saturate.
  assign plen = (plen_reg_r > LEN_W'(PATTERN_MAX)) ? CW'(PATTERN_MAX) : CW'(plen_reg_r);
  assign rlen = (rlen_reg_r > LEN_W'(REPLACE_MAX)) ? RLW'(REPLACE_MAX) : RLW'(rlen_reg_r);

  // Byte-wise compare of the buffer against the pattern, masked by length.
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      eq[i]         = (hold_r[i] == pat_r[i]);
      below_cnt[i]  = (CW'(i) < cnt_r);
      below_plen[i] = (CW'(i) < plen);
    end
  end

  assign match_cnt  = &(eq | ~below_cnt);
  assign match_plen = &(eq | ~below_plen);

  // Status toward the controller.
  always_comb begin
    status.rel_need   = (cnt_r != '0) && !((cnt_r < plen) && match_cnt);
    status.cnt_zero   = (cnt_r == '0);
    status.cnt_one    = (cnt_r == CW'(1));
    status.plen_zero  = (plen == '0);
    status.full_match = (plen != '0) && (cnt_r == plen) && match_plen;
    status.part_match = (cnt_r < plen) && match_cnt;
    status.rlen_zero  = (rlen == '0);
    status.rep_last   = ((RLW'(ridx_r) + RLW'(1)) == rlen);
    status.final_seen = final_r;
    status.pend_valid = pend_valid_r;
    status.out_free   = !out_valid_r || out_ready;
  end

  // Next contents of the hold buffer: append, shift out the head, or drop all.
  always_comb begin
    hold_nxt = hold_r;
    cnt_nxt  = cnt_r;
    if (cmd.append_in) begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
        if (CW'(i) == cnt_r) hold_nxt[i] = in_data.in_byte;
      end
      cnt_nxt = cnt_r + CW'(1);
    end
    if (cmd.emit_head) begin
      for (int i = 0; i < PATTERN_MAX - 1; i++) hold_nxt[i] = hold_r[i+1];
      cnt_nxt = cnt_r - CW'(1);
      if (cmd.append_saved) begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
          if (CW'(i) == cnt_r - CW'(1)) hold_nxt[i] = byte_r;
        end
        cnt_nxt = cnt_r;
      end
    end
    if (cmd.clear_cnt) cnt_nxt = '0;
  end

  // Buffer contents carry no reset; the count does.
  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    if (cmd.load_in) begin
      byte_r  <= in_data.in_byte;
      final_r <= in_data.in_final;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ridx_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.rep_clr) begin
        ridx_r <= '0;
      end else if (cmd.emit_rep) begin
        ridx_r <= ridx_r + RIW'(1);
      end
    end
  end

  // Each new byte parks in the pending stage; the one it displaces goes out
  // as a non-last result. The finish command marks the end of the run.
  assign emit      = cmd.emit_head || cmd.emit_rep;
  assign emit_byte = cmd.emit_head ? hold_r[0] : rep_r[ridx_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (emit) begin
        pend_valid_r <= 1'b1;
        if (pend_valid_r) out_valid_r <= 1'b1;
      end
      if (cmd.finish) begin
        pend_valid_r <= 1'b0;
        if (pend_valid_r || final_r) out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pend_byte_r <= emit_byte;
      if (pend_valid_r) begin
        out_data_r.out_byte   <= pend_byte_r;
        out_data_r.byte_valid <= 1'b1;
        out_data_r.run_last   <= 1'b0;
        out_data_r.string_end <= 1'b0;
      end
    end
    if (cmd.finish) begin
      if (pend_valid_r) begin
        out_data_r.out_byte   <= pend_byte_r;
        out_data_r.byte_valid <= 1'b1;
        out_data_r.run_last   <= 1'b1;
        out_data_r.string_end <= final_r;
      end else if (final_r) begin
        out_data_r.out_byte   <= '0;
        out_data_r.byte_valid <= 1'b0;
        out_data_r.run_last   <= 1'b1;
        out_data_r.string_end <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### design/sfr_ctrl.sv
// ----------------------------------------------------------------------------
// sfr_ctrl: sequencing state machine for find-and-replace
// Accepts one source byte at a time and walks the datapath through release,
// scan, replacement and end-of-run steps, one output byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module sfr_ctrl
  import sfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a source byte
  localparam logic [2:0] S_REL  = 3'd1;  // releasing stale held bytes
  localparam logic [2:0] S_SCAN = 3'd2;  // matching the buffer against the pattern
  localparam logic [2:0] S_REPL = 3'd3;  // sending replacement bytes
  localparam logic [2:0] S_END  = 3'd4;  // flush on final byte, then close the run

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       emit_ok;
  logic       finish_ok;

  // A new byte may be produced if the pending stage is empty or can move on.
  assign emit_ok   = !status.pend_valid || status.out_free;
  assign finish_ok = status.out_free || (!status.pend_valid && !status.final_seen);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (status.rel_need) begin
            state_nxt = S_REL;
          end else begin
            cmd.append_in = 1'b1;
            state_nxt     = S_SCAN;
          end
        end
      end
      S_REL: begin
        if (emit_ok) begin
          cmd.emit_head = 1'b1;
          if (status.cnt_one) begin
            cmd.append_saved = 1'b1;
            state_nxt        = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (status.cnt_zero) begin
          state_nxt = S_END;
        end else if (status.full_match) begin
          cmd.clear_cnt = 1'b1;
          cmd.rep_clr   = 1'b1;
          state_nxt     = status.rlen_zero ? S_END : S_REPL;
        end else if (status.part_match && !status.plen_zero) begin
          state_nxt = S_END;
        end else if (emit_ok) begin
          // Oldest byte cannot start a match: release it and check again.
          cmd.emit_head = 1'b1;
          if (status.cnt_one) state_nxt = S_END;
        end
      end
      S_REPL: begin
        if (emit_ok) begin
          cmd.emit_rep = 1'b1;
          if (status.rep_last) state_nxt = S_END;
        end
      end
      S_END: begin
        if (status.final_seen && !status.cnt_zero) begin
          if (emit_ok) cmd.emit_head = 1'b1;
        end else if (finish_ok) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/stream_find_and_replace.sv
// ----------------------------------------------------------------------------
// stream_find_and_replace: streaming find-and-replace-all over a byte string
// Replaces every leftmost, non-overlapping occurrence of a configured pattern
// with a configured replacement, holding partial matches between bytes.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   cfg_      in         cfg_we               cfg_index, cfg_data (64 bits)
//   in_       in         in_valid / in_ready  src_item_t (in_byte, in_final)
//   out_      out        out_valid/out_ready  res_item_t (out_byte, byte_valid,
//                                             run_last, string_end)
//
// One source byte is handled at a time: an item is accepted, each result byte
// it produces is sent, each full or partial pattern match found is handled,
// and the run is closed before the next source byte is taken.
// The controller steps the datapath one output byte per cycle, unless the
// output stalls, through a single pending stage and the output register.
// Reset is synchronous and active low; the held-byte buffer needs no clearing.
// A stalled output holds the controller only when the pending result or the
// end-of-string marker has nowhere to go.
//
module stream_find_and_replace
  import sfr_pkg::*;
#(
  parameter int PATTERN_MAX = 8,
  parameter int REPLACE_MAX = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  src_item_t             in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output res_item_t             out_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencing.
  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Storage, compare and output staging.
  sfr_datapath #(
    .PATTERN_MAX (PATTERN_MAX),
    .REPLACE_MAX (REPLACE_MAX)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

### design/sfr_checker.sv
// ----------------------------------------------------------------------------
// sfr_checker: port-level assertions for stream_find_and_replace
// Watches the input and result channels and checks run marking and the
// one-item-at-a-time acceptance.
// ----------------------------------------------------------------------------
module sfr_checker
  import sfr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input res_item_t out_data
);

  // A stalled result transfer keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // An end-only marker closes both the run and the string.
  a_marker_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.byte_valid |-> out_data.run_last && out_data.string_end)
    else $error("end-only marker without run and string end");

  // The end of the string is always the end of a run.
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.string_end |-> out_data.run_last)
    else $error("string end without run end");

  // After an input transfer the block is not ready in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind stream_find_and_replace sfr_checker u_sfr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
